// ----- hw/rtl/rgcs_pkg.sv -----
// Shared types and constants of the rectangular geofence channel select unit.
// No dependencies.
package rgcs_pkg;

   localparam int MAX_ENTRIES = 32;
   localparam int COORD_W     = 29;
   localparam int CHAN_W      = 8;
   localparam int RIDX_W      = 5;
   localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

   localparam logic KIND_APPEND   = 1'b0;
   localparam logic KIND_POSITION = 1'b1;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic [CHAN_W-1:0]         chan_type;
   typedef logic [IDX_W-1:0]          idx_type;
   typedef logic [CNT_W-1:0]          cnt_type;

   typedef struct packed {
      coord_type west;
      coord_type east;
      coord_type south;
      coord_type north;
      chan_type  chan;
   } region_type;

   // broadcast to every cell while a scan runs
   typedef struct packed {
      coord_type lon;
      coord_type lat;
      idx_type   cur;
      cnt_type   count;
   } query_type;

   // scan token handed from cell to cell
   typedef struct packed {
      logic     valid;
      logic     keep;
      logic     found;
      idx_type  idx;
      chan_type chan;
      chan_type def_chan;
   } token_type;

endpackage

// ----- hw/rtl/rgcs_ifc.sv -----
// Handshake channel interfaces of the geofence channel select unit.
// Depends on rgcs_pkg.
interface rgcs_req_if;
   logic                valid;
   logic                ready;
   logic                kind;
   rgcs_pkg::chan_type  region_channel;
   rgcs_pkg::coord_type bound_west;
   rgcs_pkg::coord_type bound_east;
   rgcs_pkg::coord_type bound_south;
   rgcs_pkg::coord_type bound_north;
   rgcs_pkg::coord_type position_long;
   rgcs_pkg::coord_type position_lat;

   modport source (output valid, kind, region_channel, bound_west, bound_east,
                   bound_south, bound_north, position_long, position_lat,
                   input ready);
   modport sink (input valid, kind, region_channel, bound_west, bound_east,
                 bound_south, bound_north, position_long, position_lat,
                 output ready);
endinterface

interface rgcs_rsp_if;
   logic                      valid;
   logic                      ready;
   rgcs_pkg::chan_type        channel_out;
   logic [rgcs_pkg::RIDX_W-1:0] region_index;
   logic                      append_dropped;

   modport source (output valid, channel_out, region_index, append_dropped,
                   input ready);
   modport sink (input valid, channel_out, region_index, append_dropped,
                 output ready);
endinterface

// ----- hw/rtl/rgcs_cell.sv -----
// One region cell of the scan chain: holds a region and checks the query
// against it as the scan token passes. Depends on rgcs_pkg.
module rgcs_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  rgcs_pkg::idx_type     cell_index,
   input  logic                  wr_en,
   input  rgcs_pkg::region_type  wr_data,
   input  rgcs_pkg::query_type   query,
   input  rgcs_pkg::token_type   tok_in,
   output rgcs_pkg::token_type   tok_out
);

   rgcs_pkg::region_type region_ff;
   rgcs_pkg::token_type  tok_ff;
   rgcs_pkg::token_type  tok_in_nxt;
   logic                 occupied;
   logic                 incl_hit;
   logic                 strict_hit;

   always_ff @(posedge clock) begin
      if (wr_en && (rgcs_pkg::CNT_W'(cell_index) == query.count)) begin
         region_ff <= wr_data;
      end
   end

   assign occupied = rgcs_pkg::CNT_W'(cell_index) < query.count;

   assign incl_hit = occupied && (cell_index == query.cur) &&
                     (query.lon >= region_ff.west) && (query.lon <= region_ff.east) &&
                     (query.lat >= region_ff.south) && (query.lat <= region_ff.north);

   // entry 0 is never picked by its bounds during the scan
   assign strict_hit = occupied && (cell_index != '0) &&
                       (query.lon > region_ff.west) && (query.lon < region_ff.east) &&
                       (query.lat > region_ff.south) && (query.lat < region_ff.north);

   always_comb begin
      tok_in_nxt      = tok_in;
      tok_in_nxt.keep = tok_in.keep | incl_hit;
      if (cell_index == '0) begin
         tok_in_nxt.def_chan = region_ff.chan;
      end
      if (!tok_in.found && strict_hit) begin
         tok_in_nxt.found = 1'b1;
         tok_in_nxt.idx   = cell_index;
         tok_in_nxt.chan  = region_ff.chan;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in_nxt;
      end
   end

   assign tok_out = tok_ff;

endmodule

// ----- hw/rtl/rectangular_geofence_channel_select_unit.sv -----
// Top level of the rectangular geofence channel select unit.
// Append, or position update on an empty table: the accept moves to S_EMIT, which registers rsp.valid.
// Position update: the scan is launched through launch_ff, the token walks the cell chain one
// cell per cycle, S_SCAN sees it at the chain end and S_EMIT registers rsp; one transaction is
// in flight at a time, so the next request is taken only once the unit is back in S_IDLE.
// Synchronous reset empties the table and selects region 0; stored bounds are not cleared.
module rectangular_geofence_channel_select_unit (
   input  logic          clock,
   input  logic          reset,
   rgcs_req_if.sink      req,
   rgcs_rsp_if.source    rsp
);

   typedef enum logic [1:0] {S_IDLE, S_SCAN, S_EMIT} state_type;

   state_type            state_ff;
   rgcs_pkg::cnt_type    count_ff;
   rgcs_pkg::idx_type    cur_ff;
   rgcs_pkg::chan_type   chan_ff;
   logic                 drop_ff;
   logic                 launch_ff;
   rgcs_pkg::coord_type  pos_lon_ff;
   rgcs_pkg::coord_type  pos_lat_ff;
   logic                 rsp_valid_ff;
   rgcs_pkg::chan_type   rsp_chan_ff;
   logic [rgcs_pkg::RIDX_W-1:0] rsp_idx_ff;
   logic                 rsp_drop_ff;

   logic                 accept;
   logic                 is_append;
   logic                 full;
   logic                 wr_en;
   rgcs_pkg::region_type wr_data;
   rgcs_pkg::query_type  query;
   rgcs_pkg::token_type  tok [0:rgcs_pkg::MAX_ENTRIES];

   assign req.ready = (state_ff == S_IDLE) && !reset;
   assign accept    = req.valid && req.ready;
   assign is_append = (req.kind == rgcs_pkg::KIND_APPEND);
   assign full      = (count_ff >= rgcs_pkg::CNT_W'(rgcs_pkg::MAX_ENTRIES));
   assign wr_en     = accept && is_append && !full;

   assign wr_data.west  = req.bound_west;
   assign wr_data.east  = req.bound_east;
   assign wr_data.south = req.bound_south;
   assign wr_data.north = req.bound_north;
   assign wr_data.chan  = req.region_channel;

   always_comb begin
      query.lon   = pos_lon_ff;
      query.lat   = pos_lat_ff;
      query.cur   = cur_ff;
      query.count = count_ff;
   end

   always_comb begin
      tok[0]       = '0;
      tok[0].valid = launch_ff;
   end

   for (genvar k = 0; k < rgcs_pkg::MAX_ENTRIES; k++) begin : g_cell
      rgcs_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (rgcs_pkg::IDX_W'(k)),
         .wr_en      (wr_en),
         .wr_data    (wr_data),
         .query      (query),
         .tok_in     (tok[k]),
         .tok_out    (tok[k+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         cur_ff       <= '0;
         chan_ff      <= '0;
         drop_ff      <= 1'b0;
         launch_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // a scan starts for a position update on a non-empty table
         launch_ff <= accept && !is_append && (count_ff != '0);
         if (rsp_valid_ff && rsp.ready && (state_ff != S_EMIT)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  drop_ff    <= is_append && full;
                  pos_lon_ff <= req.position_long;
                  pos_lat_ff <= req.position_lat;
                  if (is_append) begin
                     state_ff <= S_EMIT;
                     if (!full) begin
                        count_ff <= count_ff + 1'b1;
                        // first region becomes the current one
                        if (count_ff == '0) begin
                           chan_ff <= req.region_channel;
                        end
                     end
                  end else if (count_ff == '0) begin
                     state_ff <= S_EMIT;
                  end else begin
                     state_ff <= S_SCAN;
                  end
               end
            end
            S_SCAN: begin
               if (tok[rgcs_pkg::MAX_ENTRIES].valid) begin
                  state_ff <= S_EMIT;
                  if (!tok[rgcs_pkg::MAX_ENTRIES].keep) begin
                     if (tok[rgcs_pkg::MAX_ENTRIES].found) begin
                        cur_ff  <= tok[rgcs_pkg::MAX_ENTRIES].idx;
                        chan_ff <= tok[rgcs_pkg::MAX_ENTRIES].chan;
                     end else begin
                        cur_ff  <= '0;
                        chan_ff <= tok[rgcs_pkg::MAX_ENTRIES].def_chan;
                     end
                  end
               end
            end
            S_EMIT: begin
               if (!rsp_valid_ff || rsp.ready) begin
                  state_ff     <= S_IDLE;
                  rsp_valid_ff <= 1'b1;
                  rsp_chan_ff  <= chan_ff;
                  rsp_idx_ff   <= rgcs_pkg::RIDX_W'(cur_ff);
                  rsp_drop_ff  <= drop_ff;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.channel_out    = rsp_chan_ff;
   assign rsp.region_index   = rsp_idx_ff;
   assign rsp.append_dropped = rsp_drop_ff;

endmodule

// ----- hw/rtl/rgcs_checker.sv -----
// Port-level checks of the geofence channel select unit, bound to its top level.
// Depends on rgcs_pkg and rectangular_geofence_channel_select_unit.
module rgcs_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input rgcs_pkg::chan_type          rsp_channel_out,
   input logic [rgcs_pkg::RIDX_W-1:0] rsp_region_index,
   input logic                        rsp_append_dropped
);

   // one transaction in flight: no accept right after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted back to back");

   // a new result only appears after work done with the input closed
   a_result_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result appeared without preceding work");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_channel_out) &&
         $stable(rsp_region_index) && $stable(rsp_append_dropped))
      else $error("stalled result changed");

endmodule

bind rectangular_geofence_channel_select_unit rgcs_checker u_rgcs_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req.valid),
   .req_ready          (req.ready),
   .rsp_valid          (rsp.valid),
   .rsp_ready          (rsp.ready),
   .rsp_channel_out    (rsp.channel_out),
   .rsp_region_index   (rsp.region_index),
   .rsp_append_dropped (rsp.append_dropped)
);

// ----- tb/sv/rgcs_selection_checker.sv -----
// Scoreboard for the geofence channel select unit: models the region table,
// predicts one selection per request transaction and checks rsp transactions in order.
// Depends on rgcs_pkg and the channel interfaces in rgcs_ifc.
module rgcs_selection_checker
   import rgcs_pkg::*;
(
   input  logic clock,
   input  logic reset,
   rgcs_req_if  req,
   rgcs_rsp_if  rsp,
   output int   mismatch_count,
   output int   selections_pending
);

   typedef struct packed {
      chan_type          chan;
      logic [RIDX_W-1:0] idx;
      logic              dropped;
   } selection_type;

   coord_type     fence_west  [MAX_ENTRIES];
   coord_type     fence_east  [MAX_ENTRIES];
   coord_type     fence_south [MAX_ENTRIES];
   coord_type     fence_north [MAX_ENTRIES];
   chan_type      fence_chan  [MAX_ENTRIES];
   int            fence_count;
   int            fence_cur;
   selection_type expected_selections [$];

   function automatic bit covers_edges(int k, coord_type lon, coord_type lat);
      return lon >= fence_west[k] && lon <= fence_east[k] &&
             lat >= fence_south[k] && lat <= fence_north[k];
   endfunction

   function automatic bit covers_strictly(int k, coord_type lon, coord_type lat);
      return lon > fence_west[k] && lon < fence_east[k] &&
             lat > fence_south[k] && lat < fence_north[k];
   endfunction

   task automatic select_region(input logic kind, input chan_type chan,
                                input coord_type w, input coord_type e,
                                input coord_type s, input coord_type n,
                                input coord_type lon, input coord_type lat,
                                output selection_type sel);
      bit found;
      sel.dropped = 1'b0;
      if (kind == KIND_APPEND) begin
         if (fence_count >= MAX_ENTRIES) begin
            sel.dropped = 1'b1;
         end else begin
            fence_west[fence_count]  = w;
            fence_east[fence_count]  = e;
            fence_south[fence_count] = s;
            fence_north[fence_count] = n;
            fence_chan[fence_count]  = chan;
            fence_count++;
         end
      end else if (fence_count > 0) begin
         if (fence_cur >= fence_count) fence_cur = 0;
         // the current region is kept on its edges; the scan skips entry 0
         if (!covers_edges(fence_cur, lon, lat)) begin
            fence_cur = 0;
            found = 1'b0;
            for (int k = 1; k < fence_count; k++) begin
               if (!found && covers_strictly(k, lon, lat)) begin
                  fence_cur = k;
                  found = 1'b1;
               end
            end
         end
      end
      sel.chan = (fence_count > 0) ? fence_chan[fence_cur] : '0;
      sel.idx  = fence_cur[RIDX_W-1:0];
   endtask

   always @(posedge clock) begin : watch
      selection_type want;
      selection_type got;
      int            bad;
      if (reset) begin
         fence_count = 0;
         fence_cur = 0;
         expected_selections.delete();
         mismatch_count <= 0;
         selections_pending <= 0;
      end else begin
         bad = 0;
         if (rsp.valid && rsp.ready) begin
            got.chan    = rsp.channel_out;
            got.idx     = rsp.region_index;
            got.dropped = rsp.append_dropped;
            if (expected_selections.size() == 0) begin
               $display("%0t: rsp with nothing pending: expected none, got chan %0d idx %0d drop %0b",
                        $time, got.chan, got.idx, got.dropped);
               bad++;
            end else begin
               want = expected_selections.pop_front();
               if (got.chan !== want.chan) begin
                  $display("%0t: channel_out expected %0d, got %0d", $time, want.chan, got.chan);
                  bad++;
               end
               if (got.idx !== want.idx) begin
                  $display("%0t: region_index expected %0d, got %0d", $time, want.idx, got.idx);
                  bad++;
               end
               if (got.dropped !== want.dropped) begin
                  $display("%0t: append_dropped expected %0b, got %0b", $time, want.dropped,
                           got.dropped);
                  bad++;
               end
            end
         end
         if (req.valid && req.ready) begin
            select_region(req.kind, req.region_channel, req.bound_west, req.bound_east,
                          req.bound_south, req.bound_north, req.position_long,
                          req.position_lat, want);
            expected_selections.push_back(want);
         end
         if (bad != 0) mismatch_count <= mismatch_count + 1;
         selections_pending <= expected_selections.size();
      end
   end

endmodule

// ----- tb/sv/tb_rectangular_geofence_channel_select_unit.sv -----
// Top of the geofence channel select testbench: clock, reset, request and
// response traffic, verdict. Checking lives in rgcs_selection_checker.
// Depends on rgcs_pkg, rgcs_ifc, the unit and rgcs_selection_checker.
module tb_rectangular_geofence_channel_select_unit;
   import rgcs_pkg::*;

   localparam int COORD_LIMIT   = 188743680;  // 180 degrees times 2^20
   localparam int RANDOM_ITEMS  = 1080;
   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = 40;

   logic clock = 1'b0;
   logic reset;
   int   mismatch_count;
   int   selections_pending;
   bit   quiet;
   bit   hold_off_pending;

   // regions appended so far, used only to aim position updates
   int   region_w [MAX_ENTRIES];
   int   region_e [MAX_ENTRIES];
   int   region_s [MAX_ENTRIES];
   int   region_n [MAX_ENTRIES];
   int   region_total;

   rgcs_req_if req_ch ();
   rgcs_rsp_if rsp_ch ();

   rectangular_geofence_channel_select_unit uut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   rgcs_selection_checker check (
      .clock              (clock),
      .reset              (reset),
      .req                (req_ch),
      .rsp                (rsp_ch),
      .mismatch_count     (mismatch_count),
      .selections_pending (selections_pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int gap_cycles();
      return quiet ? 0 : int'($urandom_range(0, 10));
   endfunction

   function automatic int clamp_coord(int v);
      if (v > COORD_LIMIT) return COORD_LIMIT;
      if (v < -COORD_LIMIT) return -COORD_LIMIT;
      return v;
   endfunction

   function automatic int any_coord();
      if ($urandom_range(0, 15) == 0)
         return $urandom_range(0, 1) ? COORD_LIMIT : -COORD_LIMIT;
      return int'($urandom_range(0, 2 * COORD_LIMIT)) - COORD_LIMIT;
   endfunction

   // interior, on an edge, or one step outside of [lo, hi]
   function automatic int coord_near(int lo, int hi);
      case ($urandom_range(0, 5))
         0, 1, 2: return (hi - lo >= 2) ? lo + 1 + int'($urandom_range(0, hi - lo - 2)) : lo;
         3:       return lo;
         4:       return hi;
         default: return clamp_coord($urandom_range(0, 1) ? lo - 1 : hi + 1);
      endcase
   endfunction

   function automatic int span_draw();
      case ($urandom_range(0, 2))
         0:       return $urandom_range(0, 16);
         1:       return $urandom_range(0, 65536);
         default: return $urandom_range(0, 1 << 26);
      endcase
   endfunction

   task automatic send_item(input logic kind, input int chan, input int w, input int e,
                            input int s, input int n, input int lon, input int lat);
      int gap;
      gap = gap_cycles();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.kind           <= kind;
      req_ch.region_channel <= chan[CHAN_W-1:0];
      req_ch.bound_west     <= w[COORD_W-1:0];
      req_ch.bound_east     <= e[COORD_W-1:0];
      req_ch.bound_south    <= s[COORD_W-1:0];
      req_ch.bound_north    <= n[COORD_W-1:0];
      req_ch.position_long  <= lon[COORD_W-1:0];
      req_ch.position_lat   <= lat[COORD_W-1:0];
      req_ch.valid          <= 1'b1;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
   endtask

   task automatic append_region(input int chan, input int w, input int e, input int s,
                                input int n);
      if (region_total < MAX_ENTRIES) begin
         region_w[region_total] = w;
         region_e[region_total] = e;
         region_s[region_total] = s;
         region_n[region_total] = n;
         region_total++;
      end
      send_item(KIND_APPEND, chan, w, e, s, n, any_coord(), any_coord());
   endtask

   task automatic move_to(input int lon, input int lat);
      send_item(KIND_POSITION, $urandom_range(0, 255), any_coord(), any_coord(),
                any_coord(), any_coord(), lon, lat);
   endtask

   task automatic append_random();
      int cx, cy, w, e, s, n, t;
      cx = any_coord();
      cy = any_coord();
      w = clamp_coord(cx - span_draw());
      e = clamp_coord(cx + span_draw());
      s = clamp_coord(cy - span_draw());
      n = clamp_coord(cy + span_draw());
      if ($urandom_range(0, 9) == 0) begin
         t = w; w = e; e = t;
      end
      if ($urandom_range(0, 9) == 0) begin
         t = s; s = n; n = t;
      end
      append_region($urandom_range(0, 255), w, e, s, n);
   endtask

   task automatic move_random();
      int k;
      if (region_total > 0 && $urandom_range(0, 9) < 7) begin
         k = $urandom_range(0, region_total - 1);
         move_to(coord_near(region_w[k], region_e[k]), coord_near(region_s[k], region_n[k]));
      end else begin
         move_to(any_coord(), any_coord());
      end
   endtask

   // response side: random stalls, plus the long hold-offs requested by the sender
   initial begin : drain
      int stall;
      rsp_ch.ready = 1'b0;
      do @(negedge clock); while (reset);
      forever begin
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         stall = gap_cycles();
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_ch.valid && rsp_ch.ready));
         @(negedge clock);
      end
   end

   initial begin : stimulus
      int  i;
      bit  do_append;
      reset = 1'b1;
      quiet = 1'b0;
      hold_off_pending = 1'b0;
      region_total = 0;
      req_ch.valid = 1'b0;
      req_ch.kind = KIND_APPEND;
      req_ch.region_channel = '0;
      req_ch.bound_west = '0;
      req_ch.bound_east = '0;
      req_ch.bound_south = '0;
      req_ch.bound_north = '0;
      req_ch.position_long = '0;
      req_ch.position_lat = '0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // empty table
      move_to(-COORD_LIMIT, COORD_LIMIT);
      move_to(COORD_LIMIT, -COORD_LIMIT);
      // small default region, then an inverted one built from the extremes
      append_region(0, -4096, 4096, -4096, 4096);
      move_to(4096, -4096);
      append_region(255, COORD_LIMIT, -COORD_LIMIT, COORD_LIMIT, -COORD_LIMIT);
      move_to(5000, 0);
      append_region(1, -COORD_LIMIT, 0, -COORD_LIMIT, 0);
      append_region(2, 0, COORD_LIMIT, 0, COORD_LIMIT);
      move_to(-COORD_LIMIT, -10000);   // on an edge: not strictly inside
      move_to(-10000, -10000);
      move_to(0, -10000);              // edge of the current region keeps it
      move_to(10000, 10000);
      move_to(0, 0);
      move_to(-1, 1);                  // nothing matches, falls back to default
      move_to(COORD_LIMIT, COORD_LIMIT);
      move_to(100, 100);
      // overlapping region behind an earlier one: first match wins
      append_region(3, 100, 200000, 100, 200000);
      move_to(150, 150);
      move_to(5000, 5000);
      move_to(5000, 5000);

      for (i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 64 == 0) quiet = ($urandom_range(0, 3) == 0);
         if (i == 250 || i == 700) hold_off_pending = 1'b1;
         // grow the table slowly; once full, appends keep coming to be dropped
         do_append = (region_total < MAX_ENTRIES) ? ($urandom_range(0, 19) == 0)
                                                  : ($urandom_range(0, 11) == 0);
         if (do_append) append_random();
         else move_random();
      end
      req_ch.valid <= 1'b0;

      while (selections_pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("tb_rectangular_geofence_channel_select_unit: done, clean");
      else
         $display("tb_rectangular_geofence_channel_select_unit: done, errors");
      $finish;
   end

   initial begin : watchdog
      #5000000;
      $display("tb_rectangular_geofence_channel_select_unit: done, errors");
      $finish;
   end

endmodule
